>>> hw/rtl/circle_pair_intersection_macros.svh
// Assertion macros shared by the circle pair intersection RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef CIRCLE_PAIR_INTERSECTION_MACROS_SVH
`define CIRCLE_PAIR_INTERSECTION_MACROS_SVH

// Checked at every clock edge outside reset.
`define CPI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CPI_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cpi_pkg.sv
// Types, widths and outcome codes for the circle pair intersection pipeline.
// No dependencies; imported by the top level circle_pair_intersection.
package cpi_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int RAD_W = COORD_WIDTH - 1;
	localparam int MAG_W = COORD_WIDTH;          // |dx|, |dy|
	localparam int SQ_W = 2 * COORD_WIDTH;       // squares, chord factors
	localparam int D2_W = 2 * COORD_WIDTH + 1;   // squared centre distance
	localparam int K_W = 2 * COORD_WIDTH + 3;    // signed K
	localparam int KM_W = K_W - 1;               // |K|
	localparam int M_W = 4 * COORD_WIDTH;        // radicand
	localparam int ROOT_W = M_W / 2;
	localparam int NUM_W = MAG_W + KM_W + 2;     // signed numerator
	localparam int NP_W = NUM_W + 1;             // rounded dividend
	localparam int DEN_W = D2_W + 2;             // 4 * D2
	localparam int QUO_W = COORD_WIDTH + 2;
	localparam int LANES = 4;

	localparam logic [1:0] OUT_CROSS = 2'd0;
	localparam logic [1:0] OUT_APART = 2'd1;
	localparam logic [1:0] OUT_INSIDE = 2'd2;
	localparam logic [1:0] OUT_SAME = 2'd3;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_a_x;
		logic signed [COORD_WIDTH-1:0] center_a_y;
		logic [RAD_W-1:0] radius_a;
		logic signed [COORD_WIDTH-1:0] center_b_x;
		logic signed [COORD_WIDTH-1:0] center_b_y;
		logic [RAD_W-1:0] radius_b;
	} cpi_req_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic signed [COORD_WIDTH-1:0] first_x;
		logic signed [COORD_WIDTH-1:0] first_y;
		logic signed [COORD_WIDTH-1:0] second_x;
		logic signed [COORD_WIDTH-1:0] second_y;
	} cpi_rsp_t;

	// travels beside the radicand through the multiplier and the root
	typedef struct packed {
		logic valid;
		logic [1:0] outcome;
		logic [COORD_WIDTH-1:0] ax;
		logic [COORD_WIDTH-1:0] ay;
		logic dx_neg;
		logic [MAG_W-1:0] dx_mag;
		logic dy_neg;
		logic [MAG_W-1:0] dy_mag;
		logic k_neg;
		logic [KM_W-1:0] k_mag;
		logic [D2_W-1:0] d2;
	} cpi_geo_t;

	// travels beside the dx*K product
	typedef struct packed {
		logic valid;
		logic [1:0] outcome;
		logic [COORD_WIDTH-1:0] ax;
		logic [COORD_WIDTH-1:0] ay;
		logic [D2_W-1:0] d2;
		logic dxk_neg;
	} cpi_prod_t;

	// travels beside the quotients through the divider
	typedef struct packed {
		logic valid;
		logic [1:0] outcome;
		logic [COORD_WIDTH-1:0] ax;
		logic [COORD_WIDTH-1:0] ay;
		logic [LANES-1:0] neg;
	} cpi_quo_t;

endpackage

>>> hw/rtl/cpi_mul.sv
// Two stage unsigned multiplier: four half-width partial products, then their sum.
// Carries a sideband word with the operands; does not depend on cpi_pkg.
module cpi_mul #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	input  logic [SW-1:0]     side_in,
	output logic [AW+BW-1:0]  p,
	output logic [SW-1:0]     side_out
);
	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL-1:0] al;
	logic [AH-1:0] ah;
	logic [BL-1:0] bl;
	logic [BH-1:0] bh;
	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [SW-1:0] side_s1;
	logic [PW-1:0] p_s2;
	logic [SW-1:0] side_s2;

	assign al = a[AL-1:0];
	assign ah = a[AW-1:AL];
	assign bl = b[BL-1:0];
	assign bh = b[BW-1:BL];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= (AL+BL)'(al) * (AL+BL)'(bl);
			lh_s1 <= (AL+BH)'(al) * (AL+BH)'(bh);
			hl_s1 <= (AH+BL)'(ah) * (AH+BL)'(bl);
			hh_s1 <= (AH+BH)'(ah) * (AH+BH)'(bh);
			p_s2 <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
				+ (PW'(hh_s1) << (AL + BL));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
		end else if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
		end
	end

	assign p = p_s2;
	assign side_out = side_s2;

endmodule

>>> hw/rtl/cpi_sqrt.sv
// Pipelined integer square root, one root bit per stage (restoring method).
// Carries a sideband word; uses the assertion macros header.
`include "circle_pair_intersection_macros.svh"

module cpi_sqrt #(
	parameter int MW = 96,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [MW-1:0]     rad,
	input  logic [SW-1:0]     side_in,
	output logic [MW/2-1:0]   root,
	output logic [SW-1:0]     side_out
);
	localparam int RW = MW / 2;

	logic [RW+1:0] rem_s [RW];
	logic [RW-1:0] root_s [RW];
	logic [MW-1:0] rad_s [RW];
	logic [SW-1:0] side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0] rem_p;
		logic [RW-1:0] root_p;
		logic [MW-1:0] rad_p;
		logic [SW-1:0] side_p;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign root_p = '0;
			assign rad_p = rad;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p = rad_s[k-1];
			assign side_p = side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur = {rem_p[RW-1:0], rad_p[MW-1:MW-2]};
		assign trial = {root_p, 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_s[k] <= '0;
				root_s[k] <= '0;
				rad_s[k] <= '0;
				side_s[k] <= '0;
			end else if (en) begin
				rem_s[k] <= ge ? cur - trial : cur;
				root_s[k] <= {root_p[RW-2:0], ge};
				rad_s[k] <= {rad_p[MW-3:0], 2'b00};
				side_s[k] <= side_p;
			end
		end
	end

	assign root = root_s[RW-1];
	assign side_out = side_s[RW-1];

	// a floor root leaves a remainder of at most twice the root
	`CPI_ASSERT(a_sqrt_rem, (RW+2)'(rem_s[RW-1]) <= (RW+2)'({root_s[RW-1], 1'b0}), "sqrt remainder out of bound")

endmodule

>>> hw/rtl/cpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor.
// Carries a sideband word; dividend must stay below divisor times 2**QW.
module cpi_div #(
	parameter int NL = 4,
	parameter int NW = 80,
	parameter int DW = 51,
	parameter int QW = 26,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [NL-1:0][NW-1:0]      num,
	input  logic [DW-1:0]              den,
	input  logic [SW-1:0]              side_in,
	output logic [NL-1:0][QW-1:0]      quo,
	output logic [SW-1:0]              side_out
);
	localparam int XW = (NW > DW + QW) ? NW : DW + QW;

	logic [NL-1:0][XW-1:0] rem_s [QW];
	logic [NL-1:0][QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int BIT = QW - 1 - k;
		logic [NL-1:0][XW-1:0] rem_p;
		logic [NL-1:0][QW-1:0] quo_p;
		logic [DW-1:0] den_p;
		logic [SW-1:0] side_p;
		logic [XW-1:0] dsh;
		logic [NL-1:0][XW-1:0] rem_n;
		logic [NL-1:0][QW-1:0] quo_n;

		if (k == 0) begin : g_first
			for (genvar l = 0; l < NL; l++) begin : g_lane
				assign rem_p[l] = XW'(num[l]);
			end
			assign quo_p = '0;
			assign den_p = den;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
			assign den_p = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign dsh = XW'(den_p) << BIT;

		always_comb begin
			rem_n = rem_p;
			quo_n = quo_p;
			for (int l = 0; l < NL; l++) begin
				if (rem_p[l] >= dsh) begin
					rem_n[l] = rem_p[l] - dsh;
					quo_n[l][BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				quo_s[k] <= quo_n;
				den_s[k] <= den_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= side_p;
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

>>> hw/rtl/circle_pair_intersection.sv
// Top level of the circle pair intersection pipeline.
// Uses cpi_pkg, cpi_mul, cpi_sqrt, cpi_div and the assertion macros header.
//
//   channel | signals                      | word
//   --------+------------------------------+-----------
//   request | req_valid, req_ready, req    | cpi_req_t
//   result  | rsp_valid, rsp_ready, rsp    | cpi_rsp_t
//
// One circle pair enters every cycle while the pipeline is not held; its depth is
// set mostly by the square root
// (one root bit per stage) and the divider (one quotient bit per stage).
// Reset clears every valid bit; the pipeline comes up empty.
// The whole pipeline holds while a finished word waits on rsp_ready; req_ready
// stays high as long as the output register is empty or is being taken.
`include "circle_pair_intersection_macros.svh"

module circle_pair_intersection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cpi_pkg::cpi_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cpi_pkg::cpi_rsp_t rsp
);
	import cpi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int VW = CW + 3;

	function automatic logic [CW-1:0] sat_coord(input logic [VW-1:0] v);
		logic ovf;
		ovf = (v[VW-1:CW-1] != '0) && (v[VW-1:CW-1] != '1);
		if (!ovf) begin
			return v[CW-1:0];
		end
		return v[VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	function automatic logic [NUM_W-1:0] signed_of(input logic neg, input logic [NUM_W-1:0] mag);
		return neg ? NUM_W'(-mag) : mag;
	endfunction

	logic en;

	// stage 1: differences and radius sum / difference
	logic signed [CW:0] dx_d, dy_d;
	logic v_s1;
	logic [CW-1:0] ax_s1, ay_s1;
	logic dxn_s1, dyn_s1;
	logic [MAG_W-1:0] dxm_s1, dym_s1;
	logic [RAD_W-1:0] ra_s1, rb_s1, dif_s1;
	logic [CW-1:0] sum_s1;

	// stage 2: squares
	logic v_s2;
	logic [CW-1:0] ax_s2, ay_s2;
	logic dxn_s2, dyn_s2;
	logic [MAG_W-1:0] dxm_s2, dym_s2;
	logic [SQ_W-1:0] dx2_s2, dy2_s2, sum2_s2;
	logic [2*RAD_W-1:0] ra2_s2, rb2_s2, dif2_s2;

	// stage 3: D2 and ra^2 - rb^2
	logic v_s3;
	logic [CW-1:0] ax_s3, ay_s3;
	logic dxn_s3, dyn_s3;
	logic [MAG_W-1:0] dxm_s3, dym_s3;
	logic [D2_W-1:0] d2_s3;
	logic [SQ_W-1:0] sum2_s3;
	logic [2*RAD_W-1:0] dif2_s3;
	logic signed [K_W-1:0] kp_s3;

	// stage 4: classify, chord factors, K
	logic far_d, inside_d, same_d;
	logic [1:0] out_d;
	logic v_s4;
	logic [1:0] out_s4;
	logic [CW-1:0] ax_s4, ay_s4;
	logic dxn_s4, dyn_s4;
	logic [MAG_W-1:0] dxm_s4, dym_s4;
	logic [D2_W-1:0] d2_s4;
	logic [SQ_W-1:0] fa_s4, fb_s4;
	logic signed [K_W-1:0] k_s4;

	cpi_geo_t geo_in, geo_m, geo_r;
	logic [$bits(cpi_geo_t)-1:0] geo_m_vec, geo_r_vec;
	logic [M_W-1:0] m_w;
	logic [ROOT_W-1:0] root_w;

	cpi_prod_t prod_in, prod_o;
	logic [$bits(cpi_prod_t)-1:0] prod_vec;
	logic [MAG_W+KM_W-1:0] dxk_w, dyk_w;
	logic [MAG_W+ROOT_W-1:0] dxs_w, dys_w;
	logic dyk_neg_w, dxs_neg_w, dys_neg_w;

	// stage 5: signed numerators
	logic [LANES-1:0][NUM_W-1:0] num_d;
	logic [LANES-1:0][NUM_W-1:0] num_s5;
	cpi_prod_t prod_s5;

	// stage 6: rounded dividends
	logic [LANES-1:0][NP_W-1:0] np_d;
	logic [LANES-1:0] neg_d;
	logic [LANES-1:0][NP_W-1:0] np_s6;
	logic [DEN_W-1:0] den_s6;
	cpi_quo_t quo_side_s6, quo_side_o;
	logic [$bits(cpi_quo_t)-1:0] quo_side_vec;
	logic [LANES-1:0][QUO_W-1:0] quo_w;

	// stage 7: output register
	logic [LANES-1:0][VW-1:0] pt_d;
	cpi_rsp_t rsp_d;
	logic v_s7;
	cpi_rsp_t rsp_s7;

	assign en = !v_s7 || rsp_ready;
	assign req_ready = en;

	assign dx_d = $signed({req.center_b_x[CW-1], req.center_b_x})
		- $signed({req.center_a_x[CW-1], req.center_a_x});
	assign dy_d = $signed({req.center_b_y[CW-1], req.center_b_y})
		- $signed({req.center_a_y[CW-1], req.center_a_y});

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= req.center_a_x;
			ay_s1 <= req.center_a_y;
			dxn_s1 <= dx_d[CW];
			dyn_s1 <= dy_d[CW];
			dxm_s1 <= dx_d[CW] ? MAG_W'(-dx_d) : MAG_W'(dx_d);
			dym_s1 <= dy_d[CW] ? MAG_W'(-dy_d) : MAG_W'(dy_d);
			ra_s1 <= req.radius_a;
			rb_s1 <= req.radius_b;
			sum_s1 <= CW'(req.radius_a) + CW'(req.radius_b);
			dif_s1 <= (req.radius_a > req.radius_b) ? req.radius_a - req.radius_b
				: req.radius_b - req.radius_a;

			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			dxn_s2 <= dxn_s1;
			dyn_s2 <= dyn_s1;
			dxm_s2 <= dxm_s1;
			dym_s2 <= dym_s1;
			dx2_s2 <= SQ_W'(dxm_s1) * SQ_W'(dxm_s1);
			dy2_s2 <= SQ_W'(dym_s1) * SQ_W'(dym_s1);
			sum2_s2 <= SQ_W'(sum_s1) * SQ_W'(sum_s1);
			ra2_s2 <= (2*RAD_W)'(ra_s1) * (2*RAD_W)'(ra_s1);
			rb2_s2 <= (2*RAD_W)'(rb_s1) * (2*RAD_W)'(rb_s1);
			dif2_s2 <= (2*RAD_W)'(dif_s1) * (2*RAD_W)'(dif_s1);

			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			dxn_s3 <= dxn_s2;
			dyn_s3 <= dyn_s2;
			dxm_s3 <= dxm_s2;
			dym_s3 <= dym_s2;
			d2_s3 <= D2_W'(dx2_s2) + D2_W'(dy2_s2);
			sum2_s3 <= sum2_s2;
			dif2_s3 <= dif2_s2;
			kp_s3 <= $signed(K_W'(ra2_s2)) - $signed(K_W'(rb2_s2));

			out_s4 <= out_d;
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			dxn_s4 <= dxn_s3;
			dyn_s4 <= dyn_s3;
			dxm_s4 <= dxm_s3;
			dym_s4 <= dym_s3;
			d2_s4 <= d2_s3;
			// zero the factors outside the crossing case so the root sees no wrap
			fa_s4 <= (out_d == OUT_CROSS) ? SQ_W'(D2_W'(sum2_s3) - d2_s3) : '0;
			fb_s4 <= (out_d == OUT_CROSS) ? SQ_W'(d2_s3 - D2_W'(dif2_s3)) : '0;
			k_s4 <= kp_s3 + $signed(K_W'(d2_s3));
		end
	end

	assign far_d = d2_s3 > D2_W'(sum2_s3);
	assign inside_d = d2_s3 < D2_W'(dif2_s3);
	assign same_d = d2_s3 == '0;

	always_comb begin
		if (far_d) begin
			out_d = OUT_APART;
		end else if (inside_d) begin
			out_d = OUT_INSIDE;
		end else if (same_d) begin
			out_d = OUT_SAME;
		end else begin
			out_d = OUT_CROSS;
		end
	end

	always_comb begin
		geo_in.valid = v_s4;
		geo_in.outcome = out_s4;
		geo_in.ax = ax_s4;
		geo_in.ay = ay_s4;
		geo_in.dx_neg = dxn_s4;
		geo_in.dx_mag = dxm_s4;
		geo_in.dy_neg = dyn_s4;
		geo_in.dy_mag = dym_s4;
		geo_in.k_neg = k_s4[K_W-1];
		geo_in.k_mag = k_s4[K_W-1] ? KM_W'(-k_s4) : KM_W'(k_s4);
		geo_in.d2 = d2_s4;
	end

	cpi_mul #(.AW(SQ_W), .BW(SQ_W), .SW($bits(cpi_geo_t))) u_mul_rad (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(fa_s4), .b(fb_s4), .side_in(geo_in),
		.p(m_w), .side_out(geo_m_vec)
	);
	assign geo_m = geo_m_vec;

	cpi_sqrt #(.MW(M_W), .SW($bits(cpi_geo_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.rad(m_w), .side_in(geo_m),
		.root(root_w), .side_out(geo_r_vec)
	);
	assign geo_r = geo_r_vec;

	always_comb begin
		prod_in.valid = geo_r.valid;
		prod_in.outcome = geo_r.outcome;
		prod_in.ax = geo_r.ax;
		prod_in.ay = geo_r.ay;
		prod_in.d2 = geo_r.d2;
		prod_in.dxk_neg = geo_r.dx_neg ^ geo_r.k_neg;
	end

	cpi_mul #(.AW(MAG_W), .BW(KM_W), .SW($bits(cpi_prod_t))) u_mul_dxk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(geo_r.dx_mag), .b(geo_r.k_mag), .side_in(prod_in),
		.p(dxk_w), .side_out(prod_vec)
	);
	assign prod_o = prod_vec;

	cpi_mul #(.AW(MAG_W), .BW(KM_W), .SW(1)) u_mul_dyk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(geo_r.dy_mag), .b(geo_r.k_mag), .side_in(geo_r.dy_neg ^ geo_r.k_neg),
		.p(dyk_w), .side_out(dyk_neg_w)
	);

	cpi_mul #(.AW(MAG_W), .BW(ROOT_W), .SW(1)) u_mul_dxs (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(geo_r.dx_mag), .b(root_w), .side_in(geo_r.dx_neg),
		.p(dxs_w), .side_out(dxs_neg_w)
	);

	cpi_mul #(.AW(MAG_W), .BW(ROOT_W), .SW(1)) u_mul_dys (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(geo_r.dy_mag), .b(root_w), .side_in(geo_r.dy_neg),
		.p(dys_w), .side_out(dys_neg_w)
	);

	// first = foot + offset, second = foot - offset
	always_comb begin
		logic [NUM_W-1:0] sdxk, sdyk, sdxs, sdys;
		sdxk = signed_of(prod_o.dxk_neg, NUM_W'(dxk_w));
		sdyk = signed_of(dyk_neg_w, NUM_W'(dyk_w));
		sdxs = signed_of(dxs_neg_w, NUM_W'(dxs_w));
		sdys = signed_of(dys_neg_w, NUM_W'(dys_w));
		num_d[0] = sdxk - sdys;
		num_d[1] = sdyk + sdxs;
		num_d[2] = sdxk + sdys;
		num_d[3] = sdyk - sdxs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= num_d;
		end
	end

	// round half away from zero: (2|N| + Q) / (2Q) with Q = 2*D2
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			neg_d[l] = num_s5[l][NUM_W-1];
			np_d[l] = (NP_W'(neg_d[l] ? NUM_W'(-num_s5[l]) : num_s5[l]) << 1)
				+ (NP_W'(prod_s5.d2) << 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s6 <= np_d;
			den_s6 <= DEN_W'(prod_s5.d2) << 2;
		end
	end

	cpi_div #(.NL(LANES), .NW(NP_W), .DW(DEN_W), .QW(QUO_W), .SW($bits(cpi_quo_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(np_s6), .den(den_s6), .side_in(quo_side_s6),
		.quo(quo_w), .side_out(quo_side_vec)
	);
	assign quo_side_o = quo_side_vec;

	always_comb begin
		logic [VW-1:0] base;
		logic [VW-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			base = (l % 2 == 0) ? VW'($signed(quo_side_o.ax)) : VW'($signed(quo_side_o.ay));
			q = VW'(quo_w[l]);
			pt_d[l] = base + (quo_side_o.neg[l] ? VW'(-q) : q);
		end
		rsp_d.outcome = quo_side_o.outcome;
		if (quo_side_o.outcome == OUT_CROSS) begin
			rsp_d.first_x = sat_coord(pt_d[0]);
			rsp_d.first_y = sat_coord(pt_d[1]);
			rsp_d.second_x = sat_coord(pt_d[2]);
			rsp_d.second_y = sat_coord(pt_d[3]);
		end else begin
			rsp_d.first_x = '0;
			rsp_d.first_y = '0;
			rsp_d.second_x = '0;
			rsp_d.second_y = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s7 <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			prod_s5 <= '0;
			quo_side_s6 <= '0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			prod_s5 <= prod_o;
			quo_side_s6.valid <= prod_s5.valid;
			quo_side_s6.outcome <= prod_s5.outcome;
			quo_side_s6.ax <= prod_s5.ax;
			quo_side_s6.ay <= prod_s5.ay;
			quo_side_s6.neg <= neg_d;
			v_s7 <= quo_side_o.valid;
		end
	end

	assign rsp_valid = v_s7;
	assign rsp = rsp_s7;

	`CPI_ASSERT_RST(a_rst_empty, !arst_n |-> !rsp_valid, "result valid during reset")
	`CPI_ASSERT(a_zero_points, rsp_valid && rsp.outcome != OUT_CROSS |-> rsp.first_x == '0 && rsp.first_y == '0 && rsp.second_x == '0 && rsp.second_y == '0, "points not zero for a non-crossing outcome")
	`CPI_ASSERT(a_load_on_advance, $rose(rsp_valid) |-> $past(req_ready), "result appeared while the pipeline was held")

endmodule
